>>> design/ffba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// First-fit block allocator package
// Shared constants, opcodes and interface types of the allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int unsigned NUM_BLOCKS = 16;
  localparam int unsigned ADDR_W     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CNT_W      = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned DATA_W     = 16;
  localparam int unsigned BLK_W      = 4;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CFG_W      = 5;

  localparam logic [CFG_W-1:0] BLOCK_COUNT_RST = CFG_W'(16);

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ffba_ram_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } ffba_alu_req_t;

  typedef struct packed {
    logic              ge;
    logic [DATA_W-1:0] diff;
  } ffba_alu_res_t;

endpackage
`default_nettype wire

>>> design/ffba_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [AddrW-1:0]           waddr_i,
  input  wire logic [WIDTH-1:0]           wdata_i,
  input  wire logic                       re_i,
  input  wire logic [AddrW-1:0]           raddr_i,
  output      logic [WIDTH-1:0]           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> design/ffba_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator compare and subtract unit
// Compares a table entry with the request and forms the remaining size.
// ----------------------------------------------------------------------------
module ffba_alu
  import ffba_pkg::*;
(
  input  wire ffba_alu_req_t req_i,
  output      ffba_alu_res_t res_o
);

  logic [DATA_W:0] diff_ext;

  assign diff_ext    = {1'b0, req_i.a} - {1'b0, req_i.b};
  assign res_o.ge    = ~diff_ext[DATA_W];
  assign res_o.diff  = diff_ext[DATA_W-1:0];

endmodule
`default_nettype wire

>>> design/ffba_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator sequencer
// Runs load, read and first-fit scan over the free-size table and holds
// the result register.
// ----------------------------------------------------------------------------
module ffba_seq
  import ffba_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic [OP_W-1:0]     opcode_i,
  input  wire logic [BLK_W-1:0]    block_index_i,
  input  wire logic [DATA_W-1:0]   size_value_i,
  input  wire logic [CFG_W-1:0]    block_count_i,
  output      ffba_ram_req_t       ram_req_o,
  input  wire logic [DATA_W-1:0]   ram_rdata_i,
  output      ffba_alu_req_t       alu_req_o,
  input  wire ffba_alu_res_t       alu_res_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic                found_o,
  output      logic [BLK_W-1:0]    chosen_block_o,
  output      logic [DATA_W-1:0]   free_left_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [NUM_BLOCKS-1:0] valid_q, valid_d;
  logic [DATA_W-1:0]     size_q, size_d;
  logic [ADDR_W-1:0]     addr_q, addr_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      lim_q, lim_d;
  logic                  res_found_q, res_found_d;
  logic [BLK_W-1:0]      res_blk_q, res_blk_d;
  logic [DATA_W-1:0]     res_left_q, res_left_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_found_q;
  logic [BLK_W-1:0]      out_blk_q;
  logic [DATA_W-1:0]     out_left_q;
  logic                  out_load;
  logic [ADDR_W-1:0]     ent_addr;
  logic [DATA_W-1:0]     ent_data;
  logic [ADDR_W-1:0]     in_addr;
  logic                  in_range;
  logic [CNT_W-1:0]      in_lim;
  logic [CNT_W-1:0]      cnt_nxt;

  assign in_addr  = ADDR_W'(block_index_i);
  assign in_range = (32'(block_index_i) < NUM_BLOCKS);
  assign in_lim   = (32'(block_count_i) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS)
                                                      : CNT_W'(block_count_i);
  assign cnt_nxt  = cnt_q + CNT_W'(1);

  assign ent_addr = (state_q == ST_SCAN) ? cnt_q[ADDR_W-1:0] : addr_q;
  assign ent_data = valid_q[ent_addr] ? ram_rdata_i : '0;

  assign alu_req_o.a = ent_data;
  assign alu_req_o.b = size_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    size_d      = size_q;
    addr_d      = addr_q;
    cnt_d       = cnt_q;
    lim_d       = lim_q;
    res_found_d = res_found_q;
    res_blk_d   = res_blk_q;
    res_left_d  = res_left_q;
    ram_req_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          size_d      = size_value_i;
          addr_d      = in_addr;
          res_found_d = 1'b0;
          res_blk_d   = '0;
          res_left_d  = '0;
          state_d     = ST_DONE;
          case (opcode_i)
            OP_LOAD: begin
              res_blk_d = block_index_i;
              if (in_range) begin
                ram_req_o.we    = 1'b1;
                ram_req_o.waddr = in_addr;
                ram_req_o.wdata = size_value_i;
                valid_d[in_addr] = 1'b1;
                res_found_d = 1'b1;
                res_left_d  = size_value_i;
              end
            end
            OP_READ: begin
              res_blk_d = block_index_i;
              if (in_range) begin
                ram_req_o.re    = 1'b1;
                ram_req_o.raddr = in_addr;
                state_d         = ST_READ;
              end
            end
            OP_ALLOC: begin
              if (in_lim != '0) begin
                ram_req_o.re    = 1'b1;
                ram_req_o.raddr = '0;
                cnt_d           = '0;
                lim_d           = in_lim;
                state_d         = ST_SCAN;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_READ: begin
        res_found_d = 1'b1;
        res_left_d  = ent_data;
        state_d     = ST_DONE;
      end
      ST_SCAN: begin
        if (cnt_nxt < lim_q) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = cnt_nxt[ADDR_W-1:0];
        end
        if (alu_res_i.ge) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = cnt_q[ADDR_W-1:0];
          ram_req_o.wdata = alu_res_i.diff;
          valid_d[cnt_q[ADDR_W-1:0]] = 1'b1;
          res_found_d = 1'b1;
          res_blk_d   = BLK_W'(cnt_q);
          res_left_d  = alu_res_i.diff;
          state_d     = ST_DONE;
        end else if (cnt_nxt == lim_q) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_nxt;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q      <= size_d;
    addr_q      <= addr_d;
    cnt_q       <= cnt_d;
    lim_q       <= lim_d;
    res_found_q <= res_found_d;
    res_blk_q   <= res_blk_d;
    res_left_q  <= res_left_d;
    if (out_load) begin
      out_found_q <= res_found_q;
      out_blk_q   <= res_blk_q;
      out_left_q  <= res_left_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = out_found_q;
  assign chosen_block_o = out_blk_q;
  assign free_left_o    = out_left_q;

endmodule
`default_nettype wire

>>> design/first_fit_block_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// First-fit block allocator core
// Keeps a free-size table of memory blocks; loads, reads and first-fit
// allocations are served one item at a time.
// ----------------------------------------------------------------------------
// A load result passes the result register and then the output register, a
// read passes the registered RAM read data, the result register and the
// output register, and an allocation scans up to min(block_count, 16) table
// entries in turn: the scan reads one table entry per cycle from the table
// RAM and passes it through one shared compare-and-subtract unit. The next
// item is taken once the previous result has entered the output register.
// Table entries read as zero until written after reset, so no clearing pass
// is needed.
module first_fit_block_allocator_core
  import ffba_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [CFG_W-1:0]    cfg_data_i,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic [OP_W-1:0]     opcode_i,
  input  wire logic [BLK_W-1:0]    block_index_i,
  input  wire logic [DATA_W-1:0]   size_value_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic                found_o,
  output      logic [BLK_W-1:0]    chosen_block_o,
  output      logic [DATA_W-1:0]   free_left_o
);

  logic [CFG_W-1:0]  block_count_q;
  ffba_ram_req_t     ram_req;
  logic [DATA_W-1:0] ram_rdata;
  ffba_alu_req_t     alu_req;
  ffba_alu_res_t     alu_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= BLOCK_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      block_count_q <= cfg_data_i;
    end
  end

  ffba_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NUM_BLOCKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  ffba_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  ffba_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .block_index_i  (block_index_i),
    .size_value_i   (size_value_i),
    .block_count_i  (block_count_q),
    .ram_req_o      (ram_req),
    .ram_rdata_i    (ram_rdata),
    .alu_req_o      (alu_req),
    .alu_res_i      (alu_res),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .chosen_block_o (chosen_block_o),
    .free_left_o    (free_left_o)
  );

endmodule
`default_nettype wire

>>> design/ffba_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator port checker
// Watches the ports of the allocator core for handshake and result rules.
// ----------------------------------------------------------------------------
module ffba_checker
  import ffba_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic              found_o,
  input wire logic [BLK_W-1:0]  chosen_block_o,
  input wire logic [DATA_W-1:0] free_left_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(found_o) &&
      $stable(chosen_block_o) && $stable(free_left_o))
    else $error("Stalled result changed or was dropped.");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> free_left_o == '0)
    else $error("A failed operation reported a non-zero free size.");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("A second item was taken while the first was in progress.");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("A result appeared without an item in progress.");

endmodule

bind first_fit_block_allocator_core ffba_checker u_checker (.*);
`default_nettype wire
